// ===== hdl/cbc_pkg.sv =====
// ----------------------------------------------------------------------------
// cbc_pkg: shared definitions of the cartridge bank controller
// Sizes, register and area codes, result kinds and the structs that travel
// between the decode stage and the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package cbc_pkg;

   localparam int RAM_BANKS     = 4;
   localparam int ROM_BANK_BITS = 9;

   localparam int OFF_W      = 13;
   localparam int SAVE_DEPTH = RAM_BANKS * (1 << OFF_W);
   localparam int SAVE_AW    = OFF_W + $clog2(RAM_BANKS);

   // Result kinds.
   localparam logic [1:0] KIND_NONE = 2'd0;
   localparam logic [1:0] KIND_ROM  = 2'd1;
   localparam logic [1:0] KIND_RAM  = 2'd2;

   // Control areas, taken from address bits 14 to 12.
   localparam logic [2:0] AREA_ENABLE_A = 3'd0;
   localparam logic [2:0] AREA_ENABLE_B = 3'd1;
   localparam logic [2:0] AREA_ROM_LOW  = 3'd2;
   localparam logic [2:0] AREA_ROM_HIGH = 3'd3;
   localparam logic [2:0] AREA_RAM_A    = 3'd4;
   localparam logic [2:0] AREA_RAM_B    = 3'd5;

   localparam logic [7:0] ENABLE_KEY = 8'h0A;

   // Configuration register indexes.
   localparam logic [1:0] CSR_MBC_MODE    = 2'd0;
   localparam logic [1:0] CSR_CS_OVERRIDE = 2'd1;
   localparam logic [1:0] CSR_SAVE_FITTED = 2'd2;
   localparam logic [1:0] CSR_ROM_BANKED  = 2'd3;

   typedef struct packed {
      logic mbc_mode;
      logic cs_override;
      logic save_fitted;
      logic rom_banked;
   } cfg_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [22:0] rom_address;
   } res_type;

   typedef struct packed {
      logic               rd_en;
      logic               wr_en;
      logic [SAVE_AW-1:0] addr;
      logic [7:0]         data;
   } mem_req_type;

   // RAM bank modulo the number of banks; the bank value is two bits wide.
   function automatic logic [1:0] bank_wrap(input logic [1:0] bank);
      logic [1:0] r;
      r = bank;
      for (int i = 0; i < 3; i++) begin
         if (int'(r) >= RAM_BANKS) begin
            r = r - 2'(RAM_BANKS);
         end
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== hdl/cbc_ram.sv =====
// ----------------------------------------------------------------------------
// cbc_ram: generic synchronous RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module cbc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== hdl/cbc_decode.sv =====
// ----------------------------------------------------------------------------
// cbc_decode: access decode and bank registers
// Classifies one bus access, updates the bank and enable registers on
// control writes and forms the save RAM request and the ROM address.
// ----------------------------------------------------------------------------
`default_nettype none

module cbc_decode (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 accept,
   input  wire logic                 op,
   input  wire logic [15:0]          bus_address,
   input  wire logic [7:0]           write_data,
   input  wire logic                 chip_select,
   input  wire cbc_pkg::cfg_type     cfg,
   output cbc_pkg::res_type          res,
   output cbc_pkg::mem_req_type      mem_req
);

   import cbc_pkg::*;

   logic [ROM_BANK_BITS-1:0] rom_bank_ff, rom_bank_in;
   logic [1:0]               sram_page_ff, sram_page_in;
   logic [7:0]               enable_ff, enable_in;

   logic [14:0] low;
   logic [2:0]  area;
   logic        selected;
   logic        ram_window;
   logic        ctrl_write;
   logic [8:0]  bank9;
   logic [8:0]  bank_new9;
   logic [ROM_BANK_BITS-1:0] bank_masked;
   logic        bank_write;
   logic [16:0] save_wide;

   assign low        = bus_address[14:0];
   assign area       = low[14:12];
   assign selected   = chip_select | cfg.cs_override;
   assign ram_window = cfg.save_fitted & bus_address[15];
   assign bank9      = 9'(rom_bank_ff);
   assign save_wide  = {2'b00, bank_wrap(sram_page_ff), bus_address[OFF_W-1:0]};

   assign ctrl_write = accept & op & cfg.rom_banked & selected & ~ram_window;

   always_comb begin
      bank_new9  = bank9;
      bank_write = 1'b0;
      case (area) inside
         AREA_ROM_LOW: begin
            bank_write = 1'b1;
            bank_new9  = cfg.mbc_mode ? {bank9[8], write_data} : {1'b0, write_data};
         end
         AREA_ROM_HIGH: begin
            bank_write = 1'b1;
            bank_new9  = cfg.mbc_mode ? {write_data[0], bank9[7:0]} : {1'b0, write_data};
         end
         default: begin
            bank_write = 1'b0;
         end
      endcase
      bank_masked = bank_new9[ROM_BANK_BITS-1:0];
      // Bank one stands in for bank zero in the older scheme.
      if (!cfg.mbc_mode && bank_masked == '0) begin
         bank_masked = ROM_BANK_BITS'(1);
      end
   end

   always_comb begin
      rom_bank_in  = rom_bank_ff;
      sram_page_in = sram_page_ff;
      enable_in    = enable_ff;
      if (ctrl_write) begin
         case (area) inside
            AREA_ENABLE_A, AREA_ENABLE_B: begin
               if (cfg.save_fitted) begin
                  enable_in = write_data;
               end
            end
            AREA_RAM_A, AREA_RAM_B: begin
               if (cfg.save_fitted) begin
                  sram_page_in = write_data[1:0];
               end
            end
            default: begin
               if (bank_write) begin
                  rom_bank_in = bank_masked;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rom_bank_ff  <= ROM_BANK_BITS'(1);
         sram_page_ff <= 2'd0;
         enable_ff    <= 8'd0;
      end else begin
         rom_bank_ff  <= rom_bank_in;
         sram_page_ff <= sram_page_in;
         enable_ff    <= enable_in;
      end
   end

   always_comb begin
      res.kind        = KIND_NONE;
      res.rom_address = 23'd0;
      if (!cfg.rom_banked) begin
         if (!op) begin
            res.kind        = KIND_ROM;
            res.rom_address = 23'(low);
         end
      end else if (selected && !op) begin
         if (ram_window) begin
            res.kind = KIND_RAM;
         end else if (low[14]) begin
            res.kind        = KIND_ROM;
            res.rom_address = {bank9, low[13:0]};
         end else begin
            res.kind        = KIND_ROM;
            res.rom_address = 23'(low);
         end
      end
   end

   always_comb begin
      mem_req.addr  = save_wide[SAVE_AW-1:0];
      mem_req.data  = write_data;
      mem_req.rd_en = accept & ~op & cfg.rom_banked & selected & ram_window;
      mem_req.wr_en = accept & op & cfg.rom_banked & selected & ram_window
                      & (enable_ff == ENABLE_KEY);
   end

endmodule

`default_nettype wire

// ===== hdl/cartridge_bank_controller.sv =====
// ----------------------------------------------------------------------------
// cartridge_bank_controller: cartridge bank controller, top level
// Bank scheme of the older and the nine-bit kind with a banked save RAM.
//
// Usage:
// - The req_ channel takes one bus access per item: the kind (read or write)
//   in tuser, address, data byte and chip select in tdata.
// - The rsp_ channel returns exactly one item per access: what to drive
//   (nothing, ROM byte at the given address, or a save RAM byte).
// - The csr_ port sets the scheme, chip select handling, RAM presence and
//   banking; write it only while no access is in flight.
// - An access is decoded as it is accepted, where the save RAM is read or
//   written and the bank registers change; it then passes the decode stage
//   register and the output register, and its result is shown once it sits
//   in the output register. One item is accepted per cycle while no clearing
//   pass runs and the receiver does not stall.
// - The pace is set by the receiver and the clearing pass, not by the save RAM port, which serves one access a cycle.
// - After reset a clearing pass writes zero to every save RAM entry, one
//   entry a cycle, over all 32768 entries; req_tready stays low during that
//   pass while configuration writes are taken.
// - When the receiver stalls, the output register and the decode stage hold
//   their items and req_tready drops once both are full.
// ----------------------------------------------------------------------------
`default_nettype none

module cartridge_bank_controller (
   input  wire logic        clock,
   input  wire logic        reset,
   // req_tdata: bus_address[15:0], write_data[23:16], chip_select[24], zero pad
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,
   // req_tuser: op[0]
   input  wire logic [0:0]  req_tuser,
   // rsp_tdata: rom_address[22:0], ram_data[30:23], zero pad
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata,
   // rsp_tuser: drive_kind[1:0]
   output logic [1:0]       rsp_tuser,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [3:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   import cbc_pkg::*;

   cfg_type     cfg_ff, cfg_in;
   res_type     res;
   mem_req_type mem_req;

   logic               clr_busy_ff, clr_busy_in;
   logic [SAVE_AW-1:0] clr_addr_ff, clr_addr_in;

   logic               p1_valid_ff, p1_valid_in;
   logic [1:0]         p1_kind_ff;
   logic [22:0]        p1_rom_ff;
   logic               out_valid_ff, out_valid_in;
   logic [1:0]         out_kind_ff;
   logic [22:0]        out_rom_ff;
   logic [7:0]         out_ram_ff;

   logic               accept;
   logic               out_free;
   logic               p1_move;
   logic               csr_write;
   logic               ram_wr_en;
   logic [SAVE_AW-1:0] ram_wr_addr;
   logic [7:0]         ram_wr_data;
   logic [7:0]         ram_rd_data;

   // Configuration port.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_paddr[3:2])
            CSR_MBC_MODE:    cfg_in.mbc_mode    = csr_pwdata[0];
            CSR_CS_OVERRIDE: cfg_in.cs_override = csr_pwdata[0];
            CSR_SAVE_FITTED: cfg_in.save_fitted = csr_pwdata[0];
            CSR_ROM_BANKED:  cfg_in.rom_banked  = csr_pwdata[0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[3:2])
         CSR_MBC_MODE:    csr_prdata = {31'd0, cfg_ff.mbc_mode};
         CSR_CS_OVERRIDE: csr_prdata = {31'd0, cfg_ff.cs_override};
         CSR_SAVE_FITTED: csr_prdata = {31'd0, cfg_ff.save_fitted};
         CSR_ROM_BANKED:  csr_prdata = {31'd0, cfg_ff.rom_banked};
         default:         csr_prdata = 32'd0;
      endcase
   end

   // Handshake and pipeline control.
   assign out_free    = ~out_valid_ff | rsp_tready;
   assign p1_move     = p1_valid_ff & out_free;
   assign req_tready  = ~clr_busy_ff & (~p1_valid_ff | out_free);
   assign accept      = req_tvalid & req_tready;
   assign p1_valid_in = accept | (p1_valid_ff & ~out_free);
   assign out_valid_in = p1_move | (out_valid_ff & ~rsp_tready);

   // Clearing pass over the save RAM after reset.
   always_comb begin
      clr_busy_in = clr_busy_ff;
      clr_addr_in = clr_addr_ff;
      if (clr_busy_ff) begin
         clr_addr_in = clr_addr_ff + 1'b1;
         if (clr_addr_ff == SAVE_AW'(SAVE_DEPTH - 1)) begin
            clr_busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff       <= '{mbc_mode: 1'b0, cs_override: 1'b1, save_fitted: 1'b0,
                           rom_banked: 1'b1};
         clr_busy_ff  <= 1'b1;
         clr_addr_ff  <= '0;
         p1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         clr_busy_ff  <= clr_busy_in;
         clr_addr_ff  <= clr_addr_in;
         p1_valid_ff  <= p1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         p1_kind_ff <= res.kind;
         p1_rom_ff  <= res.rom_address;
      end
      // The RAM read data belongs to the item in the decode stage; it holds
      // because no new read is issued while that item waits.
      if (p1_move) begin
         out_kind_ff <= p1_kind_ff;
         out_rom_ff  <= p1_rom_ff;
         out_ram_ff  <= (p1_kind_ff == KIND_RAM) ? ram_rd_data : 8'd0;
      end
   end

   cbc_decode u_decode (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .op          (req_tuser[0]),
      .bus_address (req_tdata[15:0]),
      .write_data  (req_tdata[23:16]),
      .chip_select (req_tdata[24]),
      .cfg         (cfg_ff),
      .res         (res),
      .mem_req     (mem_req)
   );

   assign ram_wr_en   = clr_busy_ff | mem_req.wr_en;
   assign ram_wr_addr = clr_busy_ff ? clr_addr_ff : mem_req.addr;
   assign ram_wr_data = clr_busy_ff ? 8'd0 : mem_req.data;

   cbc_ram #(
      .WIDTH (8),
      .DEPTH (SAVE_DEPTH)
   ) u_save_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (mem_req.rd_en),
      .rd_addr (mem_req.addr),
      .rd_data (ram_rd_data)
   );

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {1'b0, out_ram_ff, out_rom_ff};
   assign rsp_tuser  = out_kind_ff;

endmodule

`default_nettype wire
